[src/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Action, status and payload definitions shared by the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request actions.
  localparam action_t ACT_PUSH_BACK  = 3'd0;
  localparam action_t ACT_PUSH_FRONT = 3'd1;
  localparam action_t ACT_POP_BACK   = 3'd2;
  localparam action_t ACT_POP_FRONT  = 3'd3;
  localparam action_t ACT_DUMP_FWD   = 3'd4;
  localparam action_t ACT_DUMP_BWD   = 3'd5;

  // Result status codes.
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

endpackage

[src/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values kept in a ring memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                      Content
//  s_*       in         tvalid tready tdata tuser    one request: action, value
//  m_*       out        tvalid tready tdata tuser    one result: value, fill,
//                       tlast                        status, last mark
//
// A push, a full push, and an empty pop or dump load their result in the
// request cycle; an unused action is dropped there. A pop waits for the
// registered ring read. A dump of N values makes one memory read per value.
// Reset (rst, synchronous) empties the queue; the memory is not cleared.
// A stalled result register holds the block in place until it is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] value_in
  input  logic [2:0]           s_tuser,   // [2:0] action
  // Result channel.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((32 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                               m_tdata,   // [31:0] value_out, then fill_count
  output logic [1:0]           m_tuser,   // [1:0] status
  output logic                 m_tlast    // last
);

  localparam int IW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int TDATA_W = ((32 + CW + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - dq_pkg::VALUE_W - CW;

  localparam logic [IW:0]   DEPTH_S   = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  // Ring slot arithmetic with wrap at DEPTH.
  function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] a);
    return (a == '0) ? LAST_SLOT : a - 1'b1;
  endfunction

  // Control registers.
  logic [1:0]    state, state_next;
  logic [IW-1:0] front_index, front_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] dump_slot, dump_slot_next;
  logic [CW-1:0] dump_left, dump_left_next;
  logic          dump_fwd, dump_fwd_next;

  // Result register.
  dq_pkg::value_t  out_value;
  dq_pkg::status_t out_status;
  logic [CW-1:0]   out_fill;
  logic            out_last;

  // Memory port signals.
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  dq_pkg::value_t mem_wdata;
  logic           mem_re;
  logic [IW-1:0]  mem_raddr;
  dq_pkg::value_t mem_rdata;

  // Result load.
  logic            load;
  dq_pkg::value_t  load_value;
  dq_pkg::status_t load_status;
  logic [CW-1:0]   load_fill;
  logic            load_last;

  logic out_free;
  logic accept;
  logic empty;
  logic full;
  logic [IW-1:0] back_slot;
  logic [IW-1:0] dump_step;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign empty     = (count == '0);
  assign full      = (count == FULL_CNT);
  assign back_slot = slot_add(front_index, IW'(count - 1'b1));
  assign dump_step = dump_fwd ? slot_inc(dump_slot) : slot_dec(dump_slot);

  dq_ring #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request decode, pointer update and dump sequencing.
  always_comb begin
    state_next     = state;
    front_next     = front_index;
    count_next     = count;
    dump_slot_next = dump_slot;
    dump_left_next = dump_left;
    dump_fwd_next  = dump_fwd;
    mem_we         = 1'b0;
    mem_waddr      = slot_add(front_index, IW'(count));
    mem_wdata      = s_tdata;
    mem_re         = 1'b0;
    mem_raddr      = front_index;
    load           = 1'b0;
    load_value     = '0;
    load_status    = dq_pkg::STAT_OK;
    load_fill      = count;
    load_last      = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser) inside
            dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
              load = 1'b1;
              if (full) begin
                load_status = dq_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                load_fill  = count + 1'b1;
                if (s_tuser == dq_pkg::ACT_PUSH_FRONT) begin
                  front_next = slot_dec(front_index);
                  mem_waddr  = slot_dec(front_index);
                end
              end
            end
            dq_pkg::ACT_POP_BACK, dq_pkg::ACT_POP_FRONT: begin
              if (empty) begin
                load        = 1'b1;
                load_status = dq_pkg::STAT_EMPTY;
              end else begin
                mem_re     = 1'b1;
                count_next = count - 1'b1;
                state_next = ST_POP;
                if (s_tuser == dq_pkg::ACT_POP_FRONT) begin
                  front_next = slot_inc(front_index);
                end else begin
                  mem_raddr = back_slot;
                end
              end
            end
            dq_pkg::ACT_DUMP_FWD, dq_pkg::ACT_DUMP_BWD: begin
              if (empty) begin
                load        = 1'b1;
                load_status = dq_pkg::STAT_EMPTY;
              end else begin
                mem_re         = 1'b1;
                dump_left_next = count;
                dump_fwd_next  = (s_tuser == dq_pkg::ACT_DUMP_FWD);
                state_next     = ST_DUMP;
                if (s_tuser == dq_pkg::ACT_DUMP_FWD) begin
                  dump_slot_next = front_index;
                end else begin
                  mem_raddr      = back_slot;
                  dump_slot_next = back_slot;
                end
              end
            end
            default: begin
              // Unused actions are taken and dropped.
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = mem_rdata;
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = mem_rdata;
          load_last  = (dump_left == CW'(1));
          if (dump_left == CW'(1)) begin
            state_next = ST_IDLE;
          end else begin
            mem_re         = 1'b1;
            mem_raddr      = dump_step;
            dump_slot_next = dump_step;
            dump_left_next = dump_left - 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      count       <= '0;
      dump_slot   <= '0;
      dump_left   <= '0;
      dump_fwd    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_next;
      count       <= count_next;
      dump_slot   <= dump_slot_next;
      dump_left   <= dump_left_next;
      dump_fwd    <= dump_fwd_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= load_value;
      out_status <= load_status;
      out_fill   <= load_fill;
      out_last   <= load_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_fill, out_value};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

[src/dq_ring.sv]
// ----------------------------------------------------------------------------
// dq_ring
// Entry storage of the queue: one write port and one read port with a
// registered read, so read data appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module dq_ring #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  dq_pkg::value_t  wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output dq_pkg::value_t  rdata
);

  dq_pkg::value_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sim/tb_double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking regression for the double-ended queue core. A shadow deque
// predicts every result from each accepted request. Results are compared
// field by field in arrival order. A directed opening covers empty cases,
// both value extremes and the unused actions. It is followed by
// random traffic that is biased in turn toward filling, draining or mixing.
// The random traffic runs under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;

  localparam int DEPTH       = 16;
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int TDATA_W     = ((dq_pkg::VALUE_W + FILL_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_ITEMS = 60;

  // Action codes that the block must ignore.
  localparam dq_pkg::action_t ACT_UNUSED_6 = 3'd6;
  localparam dq_pkg::action_t ACT_UNUSED_7 = 3'd7;

  typedef struct packed {
    dq_pkg::value_t      value;
    dq_pkg::status_t     status;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } deque_result_t;

  // Shadow copy of the queue and the results it still owes.
  class deque_shadow;
    dq_pkg::value_t ring [DEPTH];
    int unsigned    head_idx;
    int unsigned    count;
    deque_result_t  owed_results [$];
    int unsigned    errors;

    function new();
      head_idx = 0;
      count    = 0;
      errors   = 0;
    endfunction

    function void owe(dq_pkg::value_t v, dq_pkg::status_t s, int unsigned fill,
                      bit lst);
      deque_result_t r;
      r.value  = v;
      r.status = s;
      r.fill   = FILL_W'(fill);
      r.last   = lst;
      owed_results.push_back(r);
    endfunction

    function bit pending();
      return owed_results.size() != 0;
    endfunction

    // Update the shadow for one accepted request and queue its results.
    function void accept_request(dq_pkg::action_t act, dq_pkg::value_t val);
      int unsigned off;
      case (act)
        dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            owe('0, dq_pkg::STAT_FULL, count, 1'b1);
          end else begin
            if (act == dq_pkg::ACT_PUSH_BACK) begin
              ring[(head_idx + count) % DEPTH] = val;
            end else begin
              head_idx = (head_idx + DEPTH - 1) % DEPTH;
              ring[head_idx] = val;
            end
            count++;
            owe('0, dq_pkg::STAT_OK, count, 1'b1);
          end
        end
        dq_pkg::ACT_POP_BACK, dq_pkg::ACT_POP_FRONT: begin
          if (count == 0) begin
            owe('0, dq_pkg::STAT_EMPTY, 0, 1'b1);
          end else if (act == dq_pkg::ACT_POP_BACK) begin
            count--;
            owe(ring[(head_idx + count) % DEPTH], dq_pkg::STAT_OK, count, 1'b1);
          end else begin
            count--;
            owe(ring[head_idx], dq_pkg::STAT_OK, count, 1'b1);
            head_idx = (head_idx + 1) % DEPTH;
          end
        end
        dq_pkg::ACT_DUMP_FWD, dq_pkg::ACT_DUMP_BWD: begin
          if (count == 0) begin
            owe('0, dq_pkg::STAT_EMPTY, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              off = (act == dq_pkg::ACT_DUMP_FWD) ? i : count - 1 - i;
              owe(ring[(head_idx + off) % DEPTH], dq_pkg::STAT_OK, count,
                  i + 1 == count);
            end
          end
        end
        default: begin
          // Unused actions leave no trace.
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_result(dq_pkg::value_t v, dq_pkg::status_t s,
                               logic [FILL_W-1:0] fill, logic lst);
      deque_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected result: value_out %h status %0d fill_count %0d",
                 v, s, fill);
        return;
      end
      want = owed_results.pop_front();
      if (v !== want.value) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("value_out: expected %h, got %h", want.value, v);
      end
      if (s !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("status: expected %0d, got %0d", want.status, s);
      end
      if (fill !== want.fill) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("fill_count: expected %0d, got %0d", want.fill, fill);
      end
      if (lst !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("last: expected %0d, got %0d", want.last, lst);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;   // [31:0] value_in
  logic [2:0]         s_tuser = '0;   // [2:0] action
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;        // [31:0] value_out, [36:32] fill_count
  logic [1:0]         m_tuser;        // [1:0] status
  logic               m_tlast;

  deque_shadow shadow = new();
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count        = 0;

  double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every accepted result is checked against the shadow.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tdata[dq_pkg::VALUE_W-1:0], m_tuser,
                          m_tdata[dq_pkg::VALUE_W +: FILL_W], m_tlast);
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_core regression: fail");
      $finish;
    end
  end

  // Offer one request, idling first at the current rate, and hold it until
  // it is taken. Called and returns at a rising edge.
  task automatic send_request(dq_pkg::action_t act, dq_pkg::value_t val);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    shadow.accept_request(act, val);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending());
  endtask

  // Values lean toward the extremes now and then.
  function automatic dq_pkg::value_t pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random requests in runs of sixteen that favor filling, draining or a mix,
  // so that both the full and the empty queue come up often.
  task automatic run_random(int unsigned n_items);
    int unsigned     done_items;
    int unsigned     sent;
    int unsigned     push_pct;
    int unsigned     pop_pct;
    int unsigned     roll;
    dq_pkg::action_t act;
    done_items = 0;
    sent       = 0;
    push_pct   = 40;
    pop_pct    = 40;
    while (done_items < n_items) begin
      if (sent % 16 == 0) begin
        case ($urandom_range(2))
          0:       begin push_pct = 72; pop_pct = 18; end
          1:       begin push_pct = 18; pop_pct = 72; end
          default: begin push_pct = 40; pop_pct = 40; end
        endcase
      end
      sent++;
      roll = $urandom_range(99);
      if (roll < 3) begin
        act = $urandom_range(1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
      end else begin
        roll = $urandom_range(99);
        if (roll < push_pct)
          act = $urandom_range(1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
          act = $urandom_range(1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
        else
          act = $urandom_range(1) ? dq_pkg::ACT_DUMP_FWD : dq_pkg::ACT_DUMP_BWD;
        done_items++;
      end
      send_request(act, pick_value());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty pops and dumps, ignored actions, extremes,
    // both dump orders, and popping the only value from either end.
    send_request(dq_pkg::ACT_DUMP_FWD, 32'h0);
    send_request(dq_pkg::ACT_DUMP_BWD, 32'h0);
    send_request(dq_pkg::ACT_POP_BACK, 32'h0);
    send_request(dq_pkg::ACT_POP_FRONT, 32'h0);
    send_request(ACT_UNUSED_6, 32'h1234_5678);
    send_request(ACT_UNUSED_7, 32'hFFFF_FFFF);
    send_request(dq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    send_request(dq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(dq_pkg::ACT_PUSH_BACK, 32'h0000_0000);
    send_request(dq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(dq_pkg::ACT_DUMP_FWD, 32'h0);
    send_request(dq_pkg::ACT_DUMP_BWD, 32'h0);
    send_request(dq_pkg::ACT_POP_BACK, 32'h0);
    send_request(dq_pkg::ACT_POP_FRONT, 32'h0);
    send_request(dq_pkg::ACT_POP_FRONT, 32'h0);
    send_request(dq_pkg::ACT_POP_BACK, 32'h0);
    send_request(dq_pkg::ACT_PUSH_FRONT, 32'hA5A5_5A5A);
    send_request(dq_pkg::ACT_POP_BACK, 32'h0);
    send_request(dq_pkg::ACT_PUSH_BACK, 32'h5A5A_A5A5);
    send_request(dq_pkg::ACT_DUMP_BWD, 32'h0);
    send_request(dq_pkg::ACT_POP_FRONT, 32'h0);
    drain_results();

    // Random traffic under each idling mix, draining between mixes.
    run_random(PHASE_ITEMS);
    drain_results();
    sender_idle_pct    = 63;
    receiver_stall_pct = 0;
    run_random(PHASE_ITEMS);
    drain_results();
    sender_idle_pct    = 0;
    receiver_stall_pct = 63;
    run_random(PHASE_ITEMS);
    drain_results();
    sender_idle_pct    = 24;
    receiver_stall_pct = 24;
    run_random(PHASE_ITEMS);
    drain_results();

    // Let any stray result show up before judging.
    repeat (DEPTH + 4) @(posedge clk);
    if (shadow.errors == 0 && !shadow.pending())
      $display("double_ended_queue_core regression: pass");
    else
      $display("double_ended_queue_core regression: fail");
    $finish;
  end

endmodule
